// ===== rtl/nlc_pkg.sv =====
// Package for the numeric literal classifier.
// Holds the result codes, character constants, special-word tables and the flag bundle.
// No dependencies.
`default_nettype none

package nlc_pkg;

	localparam int WORD_COUNT = 6;

	typedef enum logic [2:0] {
		TYPE_CHAR    = 3'd0,
		TYPE_INT     = 3'd1,
		TYPE_FLOAT   = 3'd2,
		TYPE_DOUBLE  = 3'd3,
		TYPE_INVALID = 3'd4
	} type_code_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// words 0..2 give float, 3..5 give double
	localparam logic [WORD_COUNT-1:0] FLOAT_WORDS  = 6'b000111;
	localparam logic [WORD_COUNT-1:0] DOUBLE_WORDS = 6'b111000;

	typedef logic [2:0] count_t;

	function automatic count_t word_len(input int unsigned w);
		count_t len;
		begin
			unique case (w)
				0: len = 3'd4;
				1: len = 3'd5;
				2: len = 3'd5;
				3: len = 3'd3;
				4: len = 3'd4;
				5: len = 3'd4;
				default: len = 3'd0;
			endcase
			return len;
		end
	endfunction

	// character of special word w at position p; positions past the word read NUL
	function automatic logic [7:0] word_char(input int unsigned w, input count_t p);
		logic [7:0] s0, s1, s2, s3, s4;
		logic [7:0] ch;
		begin
			s0 = CH_NUL; s1 = CH_NUL; s2 = CH_NUL; s3 = CH_NUL; s4 = CH_NUL;
			unique case (w)
				0: begin s0 = CH_N; s1 = CH_A; s2 = CH_N; s3 = CH_F; end
				1: begin s0 = CH_PLUS; s1 = CH_I; s2 = CH_N; s3 = CH_F; s4 = CH_F; end
				2: begin s0 = CH_MINUS; s1 = CH_I; s2 = CH_N; s3 = CH_F; s4 = CH_F; end
				3: begin s0 = CH_N; s1 = CH_A; s2 = CH_N; end
				4: begin s0 = CH_PLUS; s1 = CH_I; s2 = CH_N; s3 = CH_F; end
				5: begin s0 = CH_MINUS; s1 = CH_I; s2 = CH_N; s3 = CH_F; end
				default: begin end
			endcase
			unique case (p)
				3'd0: ch = s0;
				3'd1: ch = s1;
				3'd2: ch = s2;
				3'd3: ch = s3;
				3'd4: ch = s4;
				default: ch = CH_NUL;
			endcase
			return ch;
		end
	endfunction

	typedef struct packed {
		logic [WORD_COUNT-1:0] matched;
		logic                  prec;
		logic                  ends_in_f;
		logic                  single_printable;
		logic                  first_nul;
		logic                  body_before;
		logic                  all_num;
		logic                  digit_seen;
		logic                  no_dot;
	} nlc_flags_t;

endpackage

`default_nettype wire

// ===== rtl/nlc_scan.sv =====
// Token scanner: per-token state registers and their next-state logic.
// Produces the flag bundle for the current character. Depends on nlc_pkg.
`default_nettype none

module nlc_scan
	import nlc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output nlc_flags_t      flags
);

	count_t                char_count_q;
	logic                  first_nul_q;
	logic                  prev_digit_q;
	logic                  dot_await_q;
	logic [1:0]            dot_total_q;
	logic                  dot_mal_q;
	logic                  body_num_q;
	logic                  digit_seen_q;
	logic [WORD_COUNT-1:0] match_q;

	count_t                count_n;
	logic                  first_nul_n;
	logic                  dot_await_n;
	logic [1:0]            dot_total_n;
	logic                  dot_mal_n;
	logic                  digit_seen_n;
	logic [WORD_COUNT-1:0] match_n;
	logic                  is_digit;
	logic                  is_dot;
	logic                  numeric_here;
	logic                  all_num;

	always_comb begin
		is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_dot   = (char_code == CH_DOT);

		for (int w = 0; w < WORD_COUNT; w++) begin
			match_n[w] = match_q[w] && (char_count_q < word_len(w)) &&
				(char_code == word_char(w, char_count_q));
		end

		dot_mal_n = dot_mal_q || (dot_await_q && !is_digit) ||
			(is_dot && (!prev_digit_q || (dot_total_q != 2'd0)));
		dot_await_n = is_dot;
		dot_total_n = (is_dot && (dot_total_q != 2'd2)) ? dot_total_q + 2'd1 : dot_total_q;

		numeric_here = is_digit || is_dot ||
			((char_count_q == 3'd0) && (char_code == CH_MINUS));
		all_num      = body_num_q && numeric_here;
		first_nul_n  = (char_count_q == 3'd0) ? (char_code == CH_NUL) : first_nul_q;
		digit_seen_n = digit_seen_q || is_digit;
		count_n      = (char_count_q != 3'd7) ? char_count_q + 3'd1 : char_count_q;

		for (int w = 0; w < WORD_COUNT; w++) begin
			flags.matched[w] = match_n[w] && (count_n == word_len(w));
		end
		flags.prec             = !dot_mal_n && !dot_await_n && (dot_total_n == 2'd1);
		flags.ends_in_f        = (char_code == CH_F);
		flags.single_printable = (count_n == 3'd1) &&
			(((char_code >= CH_BANG) && (char_code <= CH_SLASH)) ||
			 ((char_code >= CH_COLON) && (char_code <= CH_TILDE)));
		flags.first_nul        = first_nul_n;
		flags.body_before      = body_num_q;
		flags.all_num          = all_num;
		flags.digit_seen       = digit_seen_n;
		flags.no_dot           = (dot_total_n == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			first_nul_q  <= 1'b0;
			prev_digit_q <= 1'b0;
			dot_await_q  <= 1'b0;
			dot_total_q  <= '0;
			dot_mal_q    <= 1'b0;
			body_num_q   <= 1'b1;
			digit_seen_q <= 1'b0;
			match_q      <= '1;
		end else if (advance) begin
			if (last_char) begin
				char_count_q <= '0;
				first_nul_q  <= 1'b0;
				prev_digit_q <= 1'b0;
				dot_await_q  <= 1'b0;
				dot_total_q  <= '0;
				dot_mal_q    <= 1'b0;
				body_num_q   <= 1'b1;
				digit_seen_q <= 1'b0;
				match_q      <= '1;
			end else begin
				char_count_q <= count_n;
				first_nul_q  <= first_nul_n;
				prev_digit_q <= is_digit;
				dot_await_q  <= dot_await_n;
				dot_total_q  <= dot_total_n;
				dot_mal_q    <= dot_mal_n;
				body_num_q   <= all_num;
				digit_seen_q <= digit_seen_n;
				match_q      <= match_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/nlc_decide.sv =====
// Result decision: picks the type code from the scanner flags by precedence.
// Depends on nlc_pkg.
`default_nettype none

module nlc_decide
	import nlc_pkg::*;
(
	input  wire nlc_flags_t flags,
	output type_code_t      code
);

	always_comb begin
		priority if (flags.first_nul || flags.single_printable) begin
			code = TYPE_CHAR;
		end else if (((flags.matched & FLOAT_WORDS) != '0) ||
				(flags.prec && flags.ends_in_f && flags.body_before)) begin
			code = TYPE_FLOAT;
		end else if (((flags.matched & DOUBLE_WORDS) != '0) ||
				(flags.prec && flags.all_num)) begin
			code = TYPE_DOUBLE;
		end else if (flags.no_dot && flags.all_num && flags.digit_seen) begin
			code = TYPE_INT;
		end else begin
			code = TYPE_INVALID;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/numeric_literal_classifier.sv =====
// Numeric literal classifier top level: input stage, scanner, decision and result register.
// Depends on nlc_pkg, nlc_scan and nlc_decide.
//
// Characters of a token are taken one per cycle on the char channel unless char_stall is high;
// the character with last_char set ends the token, and its type code (0 char, 1 int, 2 float,
// 3 double, 4 invalid) is offered on the type channel from the result register, which follows the
// input stage register. Sustained rate is one character per cycle while not stalled, set by the
// token state update between the input stage register and the result register. A waiting result
// does not block further characters; only a second token end arriving while the result is still
// stalled holds the input.
`default_nettype none

module numeric_literal_classifier
	import nlc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            type_valid,
	input  wire logic       type_stall,
	output logic [2:0]      type_code
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       go_s1;
	logic       type_valid_q;
	type_code_t type_code_q;
	type_code_t code;
	nlc_flags_t flags;

	// a token end may leave the stage only when the result slot frees
	assign go_s1      = valid_s1 && (!last_s1 || !type_valid_q || !type_stall);
	assign char_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	nlc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (go_s1),
		.char_code (char_s1),
		.last_char (last_s1),
		.flags     (flags)
	);

	nlc_decide u_decide (
		.flags (flags),
		.code  (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			type_valid_q <= 1'b1;
		end else if (!type_stall) begin
			type_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			type_code_q <= code;
		end
	end

	assign type_valid = type_valid_q;
	assign type_code  = type_code_q;

	a_result_from_token_end: assert property (@(posedge clk) disable iff (!arst_n)
		(type_valid && !$past(type_valid)) |-> $past(valid_s1 && last_s1))
		else $error("result without a token end");

	a_mid_token_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> !char_stall)
		else $error("non-final character held");

	a_token_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && type_valid && type_stall) |=> (valid_s1 && last_s1))
		else $error("token end lost while result stalled");

endmodule

`default_nettype wire
